// ----- hw/rtl/base64_stream_decoder_macros.svh -----
// Assertion macros for the base64 stream decoder checker.
// Included by b64d_checker.sv; no other dependencies.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/b64d_pkg.sv -----
// Shared types, character codes and bit-packing functions of the base64 decoder.
// No dependencies; used by b64d_unit and base64_stream_decoder.
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   localparam logic [7:0] OFS_LOWER = 8'd26;
   localparam logic [7:0] OFS_DIGIT = 8'd52;
   localparam logic [5:0] SEXT_PLUS  = 6'd62;
   localparam logic [5:0] SEXT_SLASH = 6'd63;

   // decoder state; sextets have no reset
   typedef struct packed {
      logic [2:0][5:0] sextets;
      logic [1:0]      count;
      logic            pad;
   } b64d_state_type;

   // the results of one transaction, drained one byte per cycle while rsp_ready is high
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      num;     // 0 = no result
      logic            marker;  // bare end marker, byte_valid low
      logic            eom;     // final result ends the message
   } b64d_group_type;

   // bit 6 set: not an alphabet symbol
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         return {1'b0, d[5:0]};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + OFS_LOWER;
         return {1'b0, d[5:0]};
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0 + OFS_DIGIT;
         return {1'b0, d[5:0]};
      end else if (c == CHAR_PLUS) begin
         return {1'b0, SEXT_PLUS};
      end else if (c == CHAR_SLASH) begin
         return {1'b0, SEXT_SLASH};
      end else begin
         return 7'h40;
      end
   endfunction

   function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
      return {s0, s1[5:4]};
   endfunction

   function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
      return {s1[3:0], s2[5:2]};
   endfunction

   function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
      return {s2[1:0], s3};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/base64_stream_decoder.sv -----
// Base64 stream decoder: one character per input transaction, bytes out.
// Channels: req_* carries a character and its end-of-text flag; rsp_* carries
// one decoded byte (or a bare end marker) per transaction, with last_of_run
// on the final result of each input character and end_of_message on the
// final result of the message.
// Structure: an input register holds one accepted character; the decode step
// (b64d_unit) runs between it and a three-byte result group register, which
// drains one byte per cycle onto rsp_* while rsp_ready is high.
// Path: an accepted character is registered in the input register, and its
// results are registered in the group register once that is free.
// Throughput: one character per cycle while characters give at most one
// result and rsp_ready is high; a character that completes a quad, or an end
// flush of two bytes, holds the group register until each of its bytes is
// taken, since the output port carries a single byte.
// Stall: while rsp_ready is low the group holds and one more character is
// still taken into the input register; after that req_ready drops.
// Reset: synchronous, active high; clears both valid flags, the pending
// sextet count and the padding flag. Pending sextets themselves are not
// reset; they are only read below the count.
// Depends on b64d_pkg and b64d_unit.
`default_nettype none

module base64_stream_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   // input channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_end_of_text,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_out,
   output logic            rsp_byte_valid,
   output logic            rsp_last_of_run,
   output logic            rsp_end_of_message
);
   import b64d_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      sym_ff;
   logic            eot_ff;

   // decoder state
   logic [2:0][5:0] sext_ff;
   logic [1:0]      count_ff;
   logic            pad_ff;

   // result group register
   b64d_group_type  grp_ff, grp_in;
   logic [1:0]      idx_ff, idx_in;

   b64d_state_type  state_cur, state_nxt;
   logic            take, is_last, advance;

   assign state_cur.sextets = sext_ff;
   assign state_cur.count   = count_ff;
   assign state_cur.pad     = pad_ff;

   b64d_unit u_unit (
      .symbol      (sym_ff),
      .end_of_text (eot_ff),
      .state_cur   (state_cur),
      .state_next  (state_nxt),
      .group       (grp_in)
   );

   // output side
   assign rsp_valid          = (grp_ff.num != 2'd0);
   assign is_last            = (idx_ff == grp_ff.num - 2'd1);
   assign take               = rsp_valid && rsp_ready;
   assign rsp_byte_out       = grp_ff.bytes[idx_ff];
   assign rsp_byte_valid     = !grp_ff.marker;
   assign rsp_last_of_run    = is_last;
   assign rsp_end_of_message = grp_ff.eom && is_last;

   // the held character moves on when the group register is free or emptying
   assign advance   = in_valid_ff && (!rsp_valid || (take && is_last));
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         idx_in = 2'd0;
      end else if (take && !is_last) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   // control state and result group
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         count_ff    <= 2'd0;
         pad_ff      <= 1'b0;
         grp_ff.num  <= 2'd0;
         idx_ff      <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         idx_ff      <= idx_in;
         if (advance) begin
            count_ff      <= state_nxt.count;
            pad_ff        <= state_nxt.pad;
            grp_ff.num    <= grp_in.num;
            grp_ff.bytes  <= grp_in.bytes;
            grp_ff.marker <= grp_in.marker;
            grp_ff.eom    <= grp_in.eom;
         end else if (take && is_last) begin
            grp_ff.num <= 2'd0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sym_ff <= req_symbol;
         eot_ff <= req_end_of_text;
      end
      if (advance) begin
         sext_ff <= state_nxt.sextets;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/b64d_unit.sv -----
// Combinational decode step: one symbol against the current state.
// Depends on b64d_pkg.
`default_nettype none

module b64d_unit (
   input  wire logic [7:0]              symbol,
   input  wire logic                    end_of_text,
   input  wire b64d_pkg::b64d_state_type state_cur,
   output b64d_pkg::b64d_state_type     state_next,
   output b64d_pkg::b64d_group_type     group
);
   import b64d_pkg::*;

   logic [6:0] sx;
   logic [1:0] n;

   assign sx = sextet_of(symbol);

   always_comb begin
      state_next = state_cur;
      group      = '0;
      n          = 2'd0;

      if (!state_cur.pad) begin
         if (!sx[6]) begin
            if (state_cur.count == 2'd3) begin
               group.bytes[0] = byte0(state_cur.sextets[0], state_cur.sextets[1]);
               group.bytes[1] = byte1(state_cur.sextets[1], state_cur.sextets[2]);
               group.bytes[2] = byte2(state_cur.sextets[2], sx[5:0]);
               n = 2'd3;
               state_next.count = 2'd0;
            end else begin
               state_next.sextets[state_cur.count] = sx[5:0];
               state_next.count = state_cur.count + 2'd1;
            end
         end else if (symbol == CHAR_PAD) begin
            state_next.pad = 1'b1;
         end
      end

      // flush uses the state after this symbol
      if (end_of_text) begin
         if (state_next.count == 2'd2) begin
            group.bytes[0] = byte0(state_next.sextets[0], state_next.sextets[1]);
            n = 2'd1;
         end else if (state_next.count == 2'd3) begin
            group.bytes[0] = byte0(state_next.sextets[0], state_next.sextets[1]);
            group.bytes[1] = byte1(state_next.sextets[1], state_next.sextets[2]);
            n = 2'd2;
         end
         if (n == 2'd0) begin
            n = 2'd1;
            group.marker = 1'b1;
         end
         group.eom = 1'b1;
         state_next.count = 2'd0;
         state_next.pad   = 1'b0;
      end

      group.num = n;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/b64d_checker.sv -----
// Port-level checks for base64_stream_decoder, bound to the top level.
// Depends on base64_stream_decoder_macros.svh.
`default_nettype none

`include "base64_stream_decoder_macros.svh"

module b64d_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte_out,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_last_of_run,
   input wire logic       rsp_end_of_message
);

   `B64D_ASSERT_NOW(a_eom_is_last, clock, reset, rsp_valid && rsp_end_of_message, rsp_last_of_run, "end of message not on last result of run")

   `B64D_ASSERT_NOW(a_marker_ends_msg, clock, reset, rsp_valid && !rsp_byte_valid, rsp_end_of_message && rsp_last_of_run, "bare marker outside end of message")

   `B64D_ASSERT_NOW(a_marker_zero, clock, reset, rsp_valid && !rsp_byte_valid, rsp_byte_out == 8'd0, "bare marker carries nonzero byte")

   `B64D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte_out) && $stable(rsp_last_of_run), "stalled transaction changed")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_byte_out       (rsp_byte_out),
   .rsp_byte_valid     (rsp_byte_valid),
   .rsp_last_of_run    (rsp_last_of_run),
   .rsp_end_of_message (rsp_end_of_message)
);

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for base64_stream_decoder: a scoreboard class predicts the
// decoded bytes of every character transaction and checks them in order.
// Depends on b64d_pkg (character codes) and the base64_stream_decoder RTL.
`default_nettype none

module tb;
   import b64d_pkg::*;

   // One result transaction as the result channel carries it.
   typedef struct packed {
      bit [7:0] data;
      bit       valid;
      bit       last;
      bit       eom;
   } decoded_byte_t;

   // Decoder model with its own state; holds the bytes still to come.
   class byte_predictor;
      bit [5:0]      held_sextets[3];
      bit [1:0]      held_count;
      bit            pad_seen;
      decoded_byte_t expected_bytes[$];
      int unsigned   mismatch_count;

      function new();
         clear_state();
         mismatch_count = 0;
      endfunction

      function void clear_state();
         held_sextets = '{6'd0, 6'd0, 6'd0};
         held_count   = 2'd0;
         pad_seen     = 1'b0;
      endfunction

      // bit 6 set: not in the alphabet
      function bit [6:0] sextet_value(bit [7:0] c);
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return {1'b0, 6'(c - CHAR_UPPER_A)};
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return {1'b0, 6'(c - CHAR_LOWER_A + 26)};
         if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return {1'b0, 6'(c - CHAR_DIGIT_0 + 52)};
         if (c == CHAR_PLUS) return {1'b0, SEXT_PLUS};
         if (c == CHAR_SLASH) return {1'b0, SEXT_SLASH};
         return 7'h40;
      endfunction

      function void expect_byte(bit [7:0] value, bit valid);
         expected_bytes.push_back('{data: value, valid: valid, last: 1'b0, eom: 1'b0});
      endfunction

      task report_mismatch(string what);
         $display("ERROR @%0t: %s", $time, what);
         mismatch_count++;
      endtask

      // Accepted character transaction: queue the bytes it causes.
      function void note_character(bit [7:0] sym, bit eot);
         int        n;
         bit [6:0]  code;
         bit [23:0] quad;
         n = 0;
         if (!pad_seen) begin
            code = sextet_value(sym);
            if (!code[6]) begin
               if (held_count == 2'd3) begin
                  quad = {held_sextets[0], held_sextets[1], held_sextets[2], code[5:0]};
                  expect_byte(quad[23:16], 1'b1);
                  expect_byte(quad[15:8], 1'b1);
                  expect_byte(quad[7:0], 1'b1);
                  n = 3;
                  held_count = 2'd0;
               end else begin
                  held_sextets[held_count] = code[5:0];
                  held_count++;
               end
            end else if (sym == CHAR_PAD) begin
               pad_seen = 1'b1;
            end
         end
         if (eot) begin
            // flush: missing sextets read as zero
            quad = {held_sextets[0], held_sextets[1], held_sextets[2], 6'd0};
            if (held_count >= 2'd2) begin
               expect_byte(quad[23:16], 1'b1);
               n++;
            end
            if (held_count == 2'd3) begin
               expect_byte(quad[15:8], 1'b1);
               n++;
            end
            if (n == 0) begin
               expect_byte(8'd0, 1'b0);
               n = 1;
            end
            expected_bytes[$].eom = 1'b1;
            clear_state();
         end
         if (n > 0) expected_bytes[$].last = 1'b1;
      endfunction

      task check_byte(decoded_byte_t got);
         decoded_byte_t want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected result data=%h valid=%b last=%b eom=%b",
                                      got.data, got.valid, got.last, got.eom));
         end else begin
            want = expected_bytes.pop_front();
            if (got.data != want.data || got.valid != want.valid ||
                got.last != want.last || got.eom != want.eom)
               report_mismatch($sformatf(
                  "got data=%h valid=%b last=%b eom=%b, expected %h %b %b %b",
                  got.data, got.valid, got.last, got.eom,
                  want.data, want.valid, want.last, want.eom));
         end
      endtask
   endclass

   localparam int RANDOM_SYMBOLS = 130;
   localparam int QUIET_TAIL     = 40;   // no idling on either side at the end

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_symbol;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_byte_out;
   logic       rsp_byte_valid;
   logic       rsp_last_of_run;
   logic       rsp_end_of_message;

   byte_predictor predictor = new;
   bit            quiet = 1'b0;

   base64_stream_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_symbol         (req_symbol),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Base64 alphabet character for a sextet, used to build well-formed text.
   function automatic bit [7:0] char_of(bit [5:0] s);
      if (s < 26) return CHAR_UPPER_A + 8'(s);
      if (s < 52) return CHAR_LOWER_A + 8'(s - 26);
      if (s < 62) return CHAR_DIGIT_0 + 8'(s - 52);
      if (s == SEXT_PLUS) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // Any code the decoder skips: outside the alphabet and not the pad.
   function automatic bit [7:0] noise_code();
      bit [7:0] c;
      bit [6:0] code;
      do begin
         c    = 8'($urandom_range(0, 255));
         code = predictor.sextet_value(c);
      end while (!code[6] || c == CHAR_PAD);
      return c;
   endfunction

   // One character transaction; inputs move only at the falling edge, and an
   // optional idle burst drops valid first. Valid held high between
   // back-to-back transactions gets one assignment per step.
   task send_character(input bit [7:0] sym, input bit eot);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_symbol      <= sym;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      predictor.note_character(sym, eot);
   endtask

   // Result side: random stall bursts, ready runs in between.
   initial begin : rsp_side
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16) - 1) @(negedge clock);
         end
      end
   end

   // Every accepted result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         predictor.check_byte('{data: rsp_byte_out, valid: rsp_byte_valid,
                                last: rsp_last_of_run, eom: rsp_end_of_message});
   end

   initial begin : stimulus
      bit [7:0]  msg[$];
      bit [23:0] group;
      int        symbols_sent;
      int        kind;
      int        nbytes;
      int        left;
      int        i;
      int        k;
      int        waited;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_symbol      = 8'd0;
      req_end_of_text = 1'b0;
      symbols_sent    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fourth symbol on the end item: three bytes, the last one closes the message.
      send_character("T", 1'b0);
      send_character("W", 1'b0);
      send_character("F", 1'b0);
      send_character("u", 1'b1);
      // Skipped extremes, each alphabet range, then two pending at the end.
      send_character(8'h00, 1'b0);
      send_character(8'hFF, 1'b0);
      send_character("A", 1'b0);
      send_character("z", 1'b0);
      send_character("0", 1'b0);
      send_character("9", 1'b0);
      send_character(CHAR_PLUS, 1'b0);
      send_character(CHAR_SLASH, 1'b1);
      // One pending sextet, end on a high code: bare end marker.
      send_character("Q", 1'b0);
      send_character(8'h80, 1'b1);
      // Pad mutes the rest of the message; three pending flush to two bytes.
      send_character("a", 1'b0);
      send_character("b", 1'b0);
      send_character("c", 1'b0);
      send_character(CHAR_PAD, 1'b0);
      send_character("d", 1'b0);
      send_character(CHAR_PAD, 1'b0);
      send_character(8'h7F, 1'b1);
      // Empty message ended by the pad itself.
      send_character(CHAR_PAD, 1'b1);

      // Random messages: mostly well-formed text with random bytes, some with
      // junk after the pad, a few of raw codes.
      while (symbols_sent < RANDOM_SYMBOLS) begin
         kind = $urandom_range(0, 9);
         msg.delete();
         if (kind < 9) begin
            nbytes = $urandom_range(0, 10);
            for (i = 0; i < nbytes; i += 3) begin
               left  = nbytes - i;
               group = 24'($urandom);
               if (left == 1) group[15:0] = 16'd0;
               if (left == 2) group[7:0] = 8'd0;
               for (k = 0; k < ((left >= 3) ? 4 : left + 1); k++)
                  msg.push_back(char_of(group[23 - 6 * k -: 6]));
               if (left < 3 && $urandom_range(0, 2) != 0)
                  for (k = left; k < 3; k++) msg.push_back(CHAR_PAD);
            end
            if (kind == 8) begin
               msg.push_back(CHAR_PAD);
               for (k = $urandom_range(1, 4); k > 0; k--)
                  msg.push_back($urandom_range(0, 3) == 0 ? CHAR_PAD :
                                char_of(6'($urandom)));
            end
            if (msg.size() == 0) msg.push_back(noise_code());
         end else begin
            for (k = $urandom_range(1, 8); k > 0; k--)
               msg.push_back(8'($urandom_range(0, 255)));
         end
         for (i = 0; i < msg.size(); i++) begin
            if (symbols_sent >= RANDOM_SYMBOLS - QUIET_TAIL) quiet = 1'b1;
            if (kind < 9 && $urandom_range(0, 7) == 0) send_character(noise_code(), 1'b0);
            send_character(msg[i], i == msg.size() - 1);
            symbols_sent++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      waited = 0;
      while (predictor.expected_bytes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (predictor.expected_bytes.size() != 0)
         predictor.report_mismatch($sformatf("%0d predicted results never arrived",
                                             predictor.expected_bytes.size()));
      if (predictor.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
